[rtl/sert_pkg.sv]
package sert_pkg;

  // default sizing
  localparam int unsigned TimerSlots  = 32;
  localparam int unsigned TimeBits    = 32;
  localparam int unsigned HandleCount = 32;
  localparam int unsigned HandleBits  = 5;
  localparam int unsigned MaxResults  = 32;

  // operation codes
  typedef enum logic [1:0] {
    OpAdd    = 2'd0,
    OpAdjust = 2'd1,
    OpDelete = 2'd2,
    OpTick   = 2'd3
  } op_e;

  // result status codes
  typedef enum logic [1:0] {
    StOk     = 2'd0,
    StFull   = 2'd1,
    StAbsent = 2'd2,
    StDup    = 2'd3
  } status_e;

  // sequencer states
  typedef enum logic [5:0] {
    SIdle   = 6'b000001,
    SRemove = 6'b000010,
    SInsert = 6'b000100,
    STick   = 6'b001000,
    STickFin = 6'b010000,
    SResp   = 6'b100000
  } state_e;

endpackage

[rtl/sert_ram.sv]
module sert_ram
  import sert_pkg::*;
#(
  parameter int unsigned Width = 37,
  parameter int unsigned Depth = TimerSlots
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read, holds when not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/sorted_expiry_timer_table.sv]
// channel   direction  tdata (low bit up)                           tuser  tlast
// s_axis    in         handle[4:0] expire_time current_time pad     op     -
// m_axis    out        status[1:0] expired_valid expired_handle      -      last
//
// one item at a time; add walks the list from the tail, delete walks
// from the head, adjust does both, and tick pops the expired timers
// off the ring head one by one, all through the one-read slot memory.
// reset clears the count, ring head and presence bits; slot memory is not cleared.
// a stalled output holds the sequencer only when it has a result to deliver.
module sorted_expiry_timer_table
  import sert_pkg::*;
#(
  parameter int unsigned TIMER_SLOTS = TimerSlots,
  parameter int unsigned TIME_BITS   = TimeBits
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [71:0] s_axis_tdata_i,  // handle[4:0], expire_time[36:5], current_time[68:37]
  input  logic [1:0]  s_axis_tuser_i,  // op[1:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,  // status[1:0], expired_valid[2], expired_handle[7:3]
  output logic        m_axis_tlast_o
);

  localparam int unsigned AW = $clog2(TIMER_SLOTS);
  localparam int unsigned CW = $clog2(TIMER_SLOTS + 1);
  localparam int unsigned EW = HandleBits + TIME_BITS;
  localparam int unsigned NW = $clog2(MaxResults + 1);

  state_e state_q, state_d;
  logic [AW-1:0] head_q, head_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] ri_q, ri_d;
  logic [CW-1:0] di_q, di_d;
  logic dv_q, dv_d;
  logic flag_q, flag_d;  // found in remove, placed in insert
  logic [HandleCount-1:0] pres_q, pres_d;
  logic [NW-1:0] n_q, n_d;
  logic pend_q, pend_d;
  logic [HandleBits-1:0] pend_h_q, pend_h_d;
  status_e st_q, st_d;

  op_e op_q, op_d;
  logic [HandleBits-1:0] h_q, h_d;
  logic [TIME_BITS-1:0] t_q, t_d;
  logic [TIME_BITS-1:0] now_q, now_d;

  logic out_valid_q, out_valid_d;
  logic [7:0] out_data_q, out_data_d;
  logic out_last_q, out_last_d;

  logic we, re;
  logic [AW-1:0] waddr, raddr;
  logic [EW-1:0] wdata, rdata;

  logic out_load, out_free;
  status_e e_st;
  logic e_v, e_l;
  logic [HandleBits-1:0] e_h;

  logic [HandleBits-1:0] rd_h;
  logic [TIME_BITS-1:0] rd_t;
  logic [AW-1:0] head_inc;
  logic expired;
  logic acc;

  // logical slot to physical ring address
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] hd, input logic [CW-1:0] li);
    logic [AW:0] s;
    s = {1'b0, hd} + (AW + 1)'(li);
    if (s >= (AW + 1)'(TIMER_SLOTS)) begin
      s = s - (AW + 1)'(TIMER_SLOTS);
    end
    return s[AW-1:0];
  endfunction

  sert_ram #(
    .Width(EW),
    .Depth(TIMER_SLOTS)
  ) u_slots (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign rd_h     = rdata[HandleBits-1:0];
  assign rd_t     = rdata[EW-1:HandleBits];
  assign head_inc = (head_q == AW'(TIMER_SLOTS - 1)) ? '0 : head_q + 1'b1;
  assign expired  = (cnt_q != '0) && (rd_t <= now_q);
  assign out_free = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == SIdle);
  assign acc = s_axis_tvalid_i && s_axis_tready_o;

  // sequencer
  always_comb begin
    state_d  = state_q;
    head_d   = head_q;
    cnt_d    = cnt_q;
    ri_d     = ri_q;
    di_d     = di_q;
    dv_d     = 1'b0;
    flag_d   = flag_q;
    pres_d   = pres_q;
    n_d      = n_q;
    pend_d   = pend_q;
    pend_h_d = pend_h_q;
    st_d     = st_q;
    op_d     = op_q;
    h_d      = h_q;
    t_d      = t_q;
    now_d    = now_q;
    we       = 1'b0;
    waddr    = '0;
    wdata    = rdata;
    re       = 1'b0;
    raddr    = '0;
    out_load = 1'b0;
    e_st     = StOk;
    e_v      = 1'b0;
    e_h      = '0;
    e_l      = 1'b1;

    unique case (state_q)
      SIdle: begin
        if (acc) begin
          op_d  = op_e'(s_axis_tuser_i);
          h_d   = s_axis_tdata_i[4:0];
          t_d   = TIME_BITS'(s_axis_tdata_i[36:5]);
          now_d = TIME_BITS'(s_axis_tdata_i[68:37]);
          unique case (op_e'(s_axis_tuser_i))
            OpAdd: begin
              if (pres_q[s_axis_tdata_i[4:0]]) begin
                st_d    = StDup;
                state_d = SResp;
              end else if (cnt_q == CW'(TIMER_SLOTS)) begin
                st_d    = StFull;
                state_d = SResp;
              end else begin
                ri_d    = cnt_q;
                flag_d  = 1'b0;
                state_d = SInsert;
              end
            end
            OpAdjust, OpDelete: begin
              if (!pres_q[s_axis_tdata_i[4:0]]) begin
                st_d    = StAbsent;
                state_d = SResp;
              end else begin
                ri_d    = '0;
                flag_d  = 1'b0;
                state_d = SRemove;
              end
            end
            OpTick: begin
              re      = 1'b1;
              raddr   = head_q;
              n_d     = '0;
              pend_d  = 1'b0;
              state_d = STick;
            end
            default: state_d = SIdle;
          endcase
        end
      end

      // forward walk: find the handle, then pull the tail down one slot
      SRemove: begin
        if (dv_q) begin
          if (flag_q) begin
            we    = 1'b1;
            waddr = phys(head_q, di_q - 1'b1);
            wdata = rdata;
          end else if (rd_h == h_q) begin
            flag_d = 1'b1;
          end
        end
        if (ri_q < cnt_q) begin
          re    = 1'b1;
          raddr = phys(head_q, ri_q);
          di_d  = ri_q;
          ri_d  = ri_q + 1'b1;
          dv_d  = 1'b1;
        end else if (!dv_q) begin
          cnt_d = cnt_q - 1'b1;
          if (op_q == OpAdjust) begin
            ri_d    = cnt_q - 1'b1;
            flag_d  = 1'b0;
            state_d = SInsert;
          end else begin
            pres_d[h_q] = 1'b0;
            st_d        = StOk;
            state_d     = SResp;
          end
        end
      end

      // backward walk: push later entries up, drop the new one in behind
      SInsert: begin
        if (dv_q && !flag_q) begin
          we    = 1'b1;
          waddr = phys(head_q, di_q + 1'b1);
          if (rd_t > t_q) begin
            wdata = rdata;
          end else begin
            wdata  = {t_q, h_q};
            flag_d = 1'b1;
          end
        end
        if (ri_q != '0 && !flag_q) begin
          re    = 1'b1;
          raddr = phys(head_q, ri_q - 1'b1);
          di_d  = ri_q - 1'b1;
          ri_d  = ri_q - 1'b1;
          dv_d  = 1'b1;
        end else if (!dv_q) begin
          if (!flag_q) begin
            we    = 1'b1;
            waddr = head_q;
            wdata = {t_q, h_q};
          end
          cnt_d       = cnt_q + 1'b1;
          pres_d[h_q] = 1'b1;
          st_d        = StOk;
          state_d     = SResp;
        end
      end

      // pop expired entries off the ring head, one held back to mark last
      STick: begin
        if (expired) begin
          if (!pend_q || out_free) begin
            if (pend_q) begin
              out_load = 1'b1;
              e_v      = 1'b1;
              e_h      = pend_h_q;
              e_l      = 1'b0;
            end
            pend_d       = 1'b1;
            pend_h_d     = rd_h;
            pres_d[rd_h] = 1'b0;
            head_d       = head_inc;
            cnt_d        = cnt_q - 1'b1;
            n_d          = n_q + 1'b1;
            if (n_q == NW'(MaxResults - 1)) begin
              state_d = STickFin;
            end else begin
              re    = 1'b1;
              raddr = head_inc;
            end
          end
        end else begin
          state_d = STickFin;
        end
      end

      STickFin: begin
        if (out_free) begin
          out_load = 1'b1;
          e_v      = pend_q;
          e_h      = pend_q ? pend_h_q : '0;
          state_d  = SIdle;
        end
      end

      SResp: begin
        if (out_free) begin
          out_load = 1'b1;
          e_st     = st_q;
          state_d  = SIdle;
        end
      end

      default: state_d = SIdle;
    endcase
  end

  // output register
  always_comb begin
    out_valid_d = out_load ? 1'b1 : (m_axis_tready_i ? 1'b0 : out_valid_q);
    out_data_d  = out_load ? {e_h, e_v, e_st} : out_data_q;
    out_last_d  = out_load ? e_l : out_last_q;
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      head_q      <= '0;
      cnt_q       <= '0;
      dv_q        <= 1'b0;
      pres_q      <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      cnt_q       <= cnt_d;
      dv_q        <= dv_d;
      pres_q      <= pres_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload and walk registers
  always_ff @(posedge clk_i) begin
    ri_q       <= ri_d;
    di_q       <= di_d;
    flag_q     <= flag_d;
    n_q        <= n_d;
    pend_h_q   <= pend_h_d;
    st_q       <= st_d;
    op_q       <= op_d;
    h_q        <= h_d;
    t_q        <= t_d;
    now_q      <= now_d;
    out_data_q <= out_data_d;
    out_last_q <= out_last_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule

[tb/timer_table_checker.sv]
module timer_table_checker
  import sert_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  input  logic [71:0] s_axis_tdata_i,
  input  logic [1:0]  s_axis_tuser_i,
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  input  logic [7:0]  m_axis_tdata_i,
  input  logic        m_axis_tlast_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          expired_seen_o,
  output int          live_timers_o
);

  typedef struct packed {
    status_e    status;
    logic       fired;
    logic [4:0] handle;
    logic       last;
  } timer_result_t;

  // predicted table state
  logic [4:0]  list_handle [TimerSlots];
  logic [31:0] list_expiry [TimerSlots];
  int          list_len;
  logic [31:0] armed;
  timer_result_t expected_q[$];

  assign pending_o     = expected_q.size();
  assign live_timers_o = list_len;

  function automatic void drop_at(int pos);
    for (int i = pos; i + 1 < list_len; i++) begin
      list_handle[i] = list_handle[i + 1];
      list_expiry[i] = list_expiry[i + 1];
    end
    list_len--;
  endfunction

  function automatic void place_sorted(logic [4:0] h, logic [31:0] t);
    int pos;
    pos = 0;
    while (pos < list_len && list_expiry[pos] <= t) pos++;
    for (int i = list_len; i > pos; i--) begin
      list_handle[i] = list_handle[i - 1];
      list_expiry[i] = list_expiry[i - 1];
    end
    list_handle[pos] = h;
    list_expiry[pos] = t;
    list_len++;
  endfunction

  // work out the results of one accepted item
  function automatic void predict_timer_op(op_e op, logic [4:0] h, logic [31:0] t_exp,
                                           logic [31:0] t_now);
    status_e st;
    int n;
    int pos;
    st = StOk;
    if (op == OpTick) begin
      n = 0;
      while (n < MaxResults && list_len > 0 && list_expiry[0] <= t_now) begin
        armed[list_handle[0]] = 1'b0;
        expected_q.push_back('{StOk, 1'b1, list_handle[0], 1'b0});
        drop_at(0);
        n++;
      end
      if (n == 0) expected_q.push_back('{StOk, 1'b0, 5'd0, 1'b1});
      else expected_q[$].last = 1'b1;
      return;
    end
    if (op == OpAdd) begin
      if (armed[h]) st = StDup;
      else if (list_len >= TimerSlots) st = StFull;
      else begin
        place_sorted(h, t_exp);
        armed[h] = 1'b1;
      end
    end else if (!armed[h]) begin
      st = StAbsent;
    end else begin
      pos = 0;
      while (list_handle[pos] != h) pos++;
      drop_at(pos);
      if (op == OpAdjust) place_sorted(h, t_exp);
      else armed[h] = 1'b0;
    end
    expected_q.push_back('{st, 1'b0, 5'd0, 1'b1});
  endfunction

  task automatic report_mismatch(string what);
    $display("mismatch at %0t: %s", $realtime, what);
    fail_count_o++;
  endtask

  // watch both channels
  always @(posedge clk_i or negedge rst_ni) begin
    timer_result_t got;
    timer_result_t want;
    if (!rst_ni) begin
      list_len = 0;
      armed = '0;
      expected_q.delete();
      fail_count_o = 0;
      expired_seen_o = 0;
    end else begin
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got = '{status_e'(m_axis_tdata_i[1:0]), m_axis_tdata_i[2], m_axis_tdata_i[7:3],
                m_axis_tlast_i};
        if (expected_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result %p", got));
        end else begin
          want = expected_q.pop_front();
          if (got.fired) expired_seen_o++;
          if (got.status != want.status)
            report_mismatch($sformatf("status %0d want %0d", got.status, want.status));
          if (got.fired != want.fired)
            report_mismatch($sformatf("expired_valid %0b want %0b", got.fired, want.fired));
          if (got.handle != want.handle)
            report_mismatch($sformatf("expired_handle %0d want %0d", got.handle,
                                      want.handle));
          if (got.last != want.last)
            report_mismatch($sformatf("last %0b want %0b", got.last, want.last));
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i)
        predict_timer_op(op_e'(s_axis_tuser_i), s_axis_tdata_i[4:0], s_axis_tdata_i[36:5],
                         s_axis_tdata_i[68:37]);
    end
  end

endmodule

[tb/testbench.sv]
module testbench
  import sert_pkg::*;
();

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [71:0] s_axis_tdata_i;
  logic [1:0]  s_axis_tuser_i;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [7:0]  m_axis_tdata_o;
  logic        m_axis_tlast_o;

  int fail_count;
  int pending;
  int expired_seen;
  int live_timers;
  int items_sent;
  int quiet_cycles;
  bit stim_done;
  bit hold_sink;
  bit timed_out;

  localparam int StallLimit = 4000;
  localparam int HoldCycles = 300;

  sorted_expiry_timer_table DUT (.*);

  timer_table_checker u_checker (
    .clk_i, .rst_ni, .s_axis_tvalid_i,
    .s_axis_tready_i (s_axis_tready_o),
    .s_axis_tdata_i, .s_axis_tuser_i,
    .m_axis_tvalid_i (m_axis_tvalid_o),
    .m_axis_tready_i,
    .m_axis_tdata_i  (m_axis_tdata_o),
    .m_axis_tlast_i  (m_axis_tlast_o),
    .fail_count_o    (fail_count),
    .pending_o       (pending),
    .expired_seen_o  (expired_seen),
    .live_timers_o   (live_timers)
  );

  // clock
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i = '0;
    s_axis_tuser_i = '0;
    m_axis_tready_i = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
  end

  // one item, held until accepted, then a random gap
  task automatic send_item(op_e op, logic [4:0] h, logic [31:0] t_exp, logic [31:0] t_now);
    int gap;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= op;
    s_axis_tdata_i  <= {3'b0, t_now, t_exp, h};
    do @(posedge clk_i); while (!s_axis_tready_o);
    items_sent++;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 17);
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      s_axis_tdata_i  <= 72'({$urandom, $urandom, $urandom});
      repeat (gap) @(negedge clk_i);
    end
  endtask

  task automatic wait_drained();
    s_axis_tvalid_i <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
  endtask

  // random time biased toward a small window so ticks hit
  function automatic logic [31:0] pick_time(logic [31:0] base);
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return 32'hFFFF_FFFF - $urandom_range(0, 3);
      2: return $urandom_range(0, 3);
      default: return base + $urandom_range(0, 40);
    endcase
  endfunction

  // stimulus
  initial begin
    logic [31:0] now;
    op_e op;
    int r;
    @(posedge rst_ni);
    @(negedge clk_i);
    // directed: absent handles, empty tick, extremes, equal expiries
    send_item(OpDelete, 5'd31, '1, '1);
    send_item(OpAdjust, 5'd0, '0, '0);
    send_item(OpTick, 5'd0, '0, 32'd0);
    send_item(OpAdd, 5'd0, 32'hFFFF_FFFF, '0);
    send_item(OpAdd, 5'd0, 32'd5, '0);
    send_item(OpAdd, 5'd31, 32'd0, '0);
    send_item(OpAdd, 5'd7, 32'd10, '0);
    send_item(OpAdd, 5'd8, 32'd10, '0);
    send_item(OpAdjust, 5'd31, 32'd10, '0);
    send_item(OpAdjust, 5'd8, 32'd1, '0);
    send_item(OpDelete, 5'd7, '0, '0);
    send_item(OpDelete, 5'd7, '0, '0);
    send_item(OpTick, 5'd0, '0, 32'd10);
    send_item(OpTick, 5'd0, '0, 32'hFFFF_FFFF);
    // fill the table, then add a duplicate handle
    for (int h = 0; h < 32; h++) send_item(OpAdd, 5'(h), 32'(h % 4), '0);
    send_item(OpAdd, 5'd3, 32'd1, '0);
    wait_drained();
    // all 32 expire in one tick under a long receiver hold-off
    hold_sink = 1'b1;
    send_item(OpTick, 5'd0, '0, 32'd3);
    send_item(OpAdd, 5'd4, 32'd9, '0);
    send_item(OpTick, 5'd0, '0, 32'd100);
    wait_drained();
    repeat (40) @(negedge clk_i);
    // random: adds, adjusts, deletes and ticks with advancing time
    now = 32'd1000;
    for (int i = 0; i < 420; i++) begin
      r = $urandom_range(0, 99);
      if (live_timers < 6 && r < 70) op = OpAdd;
      else if (r < 40) op = OpAdd;
      else if (r < 55) op = OpAdjust;
      else if (r < 68) op = OpDelete;
      else op = OpTick;
      if (op == OpTick) now += $urandom_range(0, 25);
      send_item(op, 5'($urandom), pick_time(now), $urandom_range(0, 19) == 0 ? $urandom :
                now);
    end
    wait_drained();
    repeat (80) @(negedge clk_i);
    stim_done = 1'b1;
  end

  // receiver readiness
  initial begin
    int stall;
    m_axis_tready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_sink) begin
        // long hold-off, counted here
        m_axis_tready_i <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
        hold_sink = 1'b0;
      end else if (m_axis_tready_i && !(m_axis_tvalid_o)) begin
        m_axis_tready_i <= 1'b1;
      end else begin
        stall = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 17);
        if (stall == 0) begin
          m_axis_tready_i <= 1'b1;
        end else begin
          m_axis_tready_i <= 1'b0;
          repeat (stall) @(negedge clk_i);
          m_axis_tready_i <= 1'b1;
        end
      end
    end
  end

  // watchdog and verdict
  initial begin
    @(posedge rst_ni);
    while (!stim_done && !timed_out) begin
      @(posedge clk_i);
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= StallLimit) timed_out = 1'b1;
    end
    if (timed_out) begin
      $display("timeout after %0d idle cycles", quiet_cycles);
      $display("simulation failed");
    end else begin
      $display("covered %0d items: adds to full, duplicates, absent handles, adjusts,",
               items_sent);
      $display("deletes and ticks with %0d timers expired", expired_seen);
      if (fail_count == 0 && pending == 0) begin
        $display("simulation ok");
      end else begin
        $display("simulation failed");
      end
    end
    $finish;
  end

endmodule
